[rtl/gmde_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gmde_pkg: shared types, constants and helpers
// Request/response bundles for the shared multiplier and divider, fixed-point
// constants and saturation helpers of the mixture density evaluator.
// ----------------------------------------------------------------------------
package gmde_pkg;

    localparam logic [2:0] CFG_COUNT   = 3'd0;
    localparam logic [2:0] CFG_WEIGHT0 = 3'd1;
    localparam logic [2:0] CFG_SIGMA0  = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    localparam logic [31:0] LOG2E_Q31      = 32'd3098164009;
    localparam logic [30:0] LN2_Q31        = 31'd1488522236;
    localparam logic [31:0] LN2_Q32        = 32'd2977044472;
    localparam logic [30:0] INVSQRT2PI_Q32 = 31'd1713444047;
    localparam logic [31:0] ONE31          = 32'h8000_0000;
    localparam logic [63:0] LIM61          = 64'h2000_0000_0000_0000;
    localparam logic [47:0] OUT_MAX        = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] OUT_MIN        = 48'h8000_0000_0000;

    typedef struct packed {
        logic        start;
        logic [63:0] op_a;
        logic [63:0] op_b;
    } t_mul_req;

    typedef struct packed {
        logic         done;
        logic [127:0] prod;
    } t_mul_rsp;

    typedef struct packed {
        logic        start;
        logic [95:0] dividend;
        logic [63:0] divisor;
        logic [6:0]  nbits;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
        logic        ovf;
    } t_div_rsp;

    function automatic t_mul_req mul_go(input logic [63:0] a, input logic [63:0] b);
        mul_go = '{1'b1, a, b};
    endfunction

    function automatic t_div_req div_go(input logic [95:0] d, input logic [63:0] v,
                                        input logic [6:0] n);
        div_go = '{1'b1, d, v, n};
    endfunction

    // ceil(2^36 / k); (n * recip) >> 36 is floor(n / k) for any n below 2^32
    function automatic logic [36:0] horner_recip(input logic [3:0] k);
        case (k)
            4'd1:    horner_recip = 37'd68719476736;
            4'd2:    horner_recip = 37'd34359738368;
            4'd3:    horner_recip = 37'd22906492246;
            4'd4:    horner_recip = 37'd17179869184;
            4'd5:    horner_recip = 37'd13743895348;
            4'd6:    horner_recip = 37'd11453246123;
            4'd7:    horner_recip = 37'd9817068106;
            4'd8:    horner_recip = 37'd8589934592;
            4'd9:    horner_recip = 37'd7635497416;
            4'd10:   horner_recip = 37'd6871947674;
            4'd11:   horner_recip = 37'd6247225158;
            4'd12:   horner_recip = 37'd5726623062;
            default: horner_recip = 37'd0;
        endcase
    endfunction

    // (p >> sh), all ones when it does not fit 64 bits
    function automatic logic [63:0] mulshr(input logic [127:0] p, input int unsigned sh);
        logic [127:0] s;
        s = p >> sh;
        mulshr = (s[127:64] != 64'd0) ? '1 : s[63:0];
    endfunction

    // [48] clamp flag, [47:0] clamped value
    function automatic logic [48:0] sat48(input logic signed [63:0] v);
        if (v > 64'sh0000_7FFF_FFFF_FFFF) begin
            sat48 = {1'b1, OUT_MAX};
        end else if (v < 64'shFFFF_8000_0000_0000) begin
            sat48 = {1'b1, OUT_MIN};
        end else begin
            sat48 = {1'b0, v[47:0]};
        end
    endfunction

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) begin
            sat_add = a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        end else begin
            sat_add = s;
        end
    endfunction

    function automatic logic [63:0] lim61(input logic [63:0] q, input logic ovf);
        lim61 = (ovf || q > LIM61) ? LIM61 : q;
    endfunction

endpackage
`default_nettype wire

[rtl/gmde_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gmde_mul: shared 64x64 multiplier
// Full 128-bit product from four 32x32 partial products, one per cycle,
// each registered before it is accumulated.
// ----------------------------------------------------------------------------
module gmde_mul
    import gmde_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mul_req i_req,
    output t_mul_rsp      o_rsp
);

    logic         r_busy;
    logic [2:0]   r_cnt;
    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic [63:0]  r_prod;
    logic [1:0]   r_pidx;
    logic         r_pv;
    logic [127:0] r_acc;
    logic         r_done;

    logic [31:0]  w_ap;
    logic [31:0]  w_bp;
    logic [63:0]  w_pp;
    logic [127:0] w_term;

    assign w_ap = r_cnt[1] ? r_a[63:32] : r_a[31:0];
    assign w_bp = r_cnt[0] ? r_b[63:32] : r_b[31:0];
    assign w_pp = w_ap * w_bp;

    always_comb begin
        case (r_pidx)
            2'd0:    w_term = {64'd0, r_prod};
            2'd3:    w_term = {r_prod, 64'd0};
            default: w_term = {32'd0, r_prod, 32'd0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pv   <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_a    <= i_req.op_a;
                r_b    <= i_req.op_b;
                r_cnt  <= 3'd0;
                r_busy <= 1'b1;
                r_pv   <= 1'b0;
                r_acc  <= '0;
            end else if (r_busy) begin
                if (r_cnt != 3'd4) begin
                    r_prod <= w_pp;
                    r_pidx <= r_cnt[1:0];
                    r_pv   <= 1'b1;
                    r_cnt  <= r_cnt + 3'd1;
                end else begin
                    r_pv <= 1'b0;
                end
                if (r_pv) begin
                    r_acc <= r_acc + w_term;
                    if (r_pidx == 2'd3) begin
                        r_done <= 1'b1;
                        r_busy <= 1'b0;
                    end
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;

endmodule
`default_nettype wire

[rtl/gmde_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gmde_div: shared restoring divider
// One quotient bit per cycle over the top nbits of a left-aligned 96-bit
// dividend; flags quotient bits lost above bit 63.
// ----------------------------------------------------------------------------
module gmde_div
    import gmde_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic [6:0]  r_cnt;
    logic [95:0] r_d;
    logic [63:0] r_den;
    logic [63:0] r_rem;
    logic [63:0] r_q;
    logic        r_ovf;

    logic [64:0] w_rs;
    logic [64:0] w_diff;
    logic        w_ge;

    assign w_rs   = {r_rem, r_d[95]};
    assign w_ge   = w_rs >= {1'b0, r_den};
    assign w_diff = w_rs - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 7'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_d    <= i_req.dividend;
                r_den  <= i_req.divisor;
                r_rem  <= '0;
                r_q    <= '0;
                r_ovf  <= 1'b0;
                r_cnt  <= i_req.nbits;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_d   <= {r_d[94:0], 1'b0};
                r_rem <= w_ge ? w_diff[63:0] : w_rs[63:0];
                r_q   <= {r_q[62:0], w_ge};
                r_ovf <= r_ovf | r_q[63];
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_q;
    assign o_rsp.ovf  = r_ovf;

endmodule
`default_nettype wire

[rtl/gaussian_mixture_density_eval.sv]
`timescale 1ns / 1ps
`default_nettype none
// Each component in use adds a pass through the shared multiplier and divider (a short pass
// when its Gaussian term underflows). A zero density skips the logarithm and ratio steps.
// The input stalls until the sequencer idles, so a new sample is taken only once the
// result of the last one has been registered at the output.
// Reset (synchronous, active low) idles the sequencer, drops the output and
// loads count 1, weights 65535/0/0, sigmas 256.
// ----------------------------------------------------------------------------
// gaussian_mixture_density_eval: zero-mean Gaussian mixture density evaluator
// Sequencer that drives one shared multiplier and one shared divider to form
// p, p', p'', -ln p and its derivatives in fixed point.
// ----------------------------------------------------------------------------
module gaussian_mixture_density_eval
    import gmde_pkg::*;
#(
    parameter int MAX_COMPONENTS = 3
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [23:0] i_x_value,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [46:0]             o_density,
    output logic signed [47:0]      o_density_slope,
    output logic signed [47:0]      o_density_curvature,
    output logic signed [47:0]      o_energy,
    output logic signed [47:0]      o_energy_slope,
    output logic signed [47:0]      o_energy_curvature,
    output logic [1:0]              o_status,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [15:0]        i_cfg_wdata
);

    localparam int KW  = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
    localparam int KCW = $clog2(MAX_COMPONENTS + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_AX2, S_NEXT, S_SS, S_SSS, S_T, S_Y, S_Z, S_HM, S_HD,
        S_WG, S_M, S_A, S_B, S_D, S_C, S_FIN, S_NORM, S_LSQ, S_LN,
        S_R, S_R2, S_Q, S_OUT
    } t_state;

    t_state      r_state;
    logic [1:0]  r_ccount;
    logic [15:0] r_weight [MAX_COMPONENTS];
    logic [15:0] r_sigma  [MAX_COMPONENTS];

    t_mul_req r_mreq;
    t_mul_rsp w_mrsp;
    t_div_req r_dreq;
    t_div_rsp w_drsp;

    logic [23:0]  r_ax;
    logic         r_xneg;
    logic [KCW-1:0] r_cnt;
    logic [KCW-1:0] r_k;
    logic [46:0]  r_ax2;
    logic [31:0]  r_ss;
    logic [47:0]  r_sss;
    logic [37:0]  r_t;
    logic [6:0]   r_n;
    logic [30:0]  r_z;
    logic [3:0]   r_kk;
    logic [61:0]  r_m;
    logic [55:0]  r_b;
    logic         r_cneg;
    logic [63:0]  r_psum;
    logic [63:0]  r_dsum;
    logic [63:0]  r_s2;
    logic [63:0]  r_mant;
    logic [5:0]   r_msb;
    logic [31:0]  r_frac;
    logic [4:0]   r_it;
    logic         r_l2neg;
    logic [63:0]  r_en;
    logic [63:0]  r_r;
    logic [63:0]  r_r2;
    logic [63:0]  r_q;

    logic         r_ovalid;
    logic [46:0]  r_o_dens;
    logic [47:0]  r_o_dslope;
    logic [47:0]  r_o_dcurv;
    logic [47:0]  r_o_en;
    logic [47:0]  r_o_eslope;
    logic [47:0]  r_o_ecurv;
    logic [1:0]   r_o_status;

    logic [KW-1:0]  w_idx;
    logic [15:0]    w_w;
    logic [15:0]    w_sraw;
    logic [15:0]    w_s;
    logic [1:0]     w_cc;
    logic [KCW-1:0] w_cnt;
    logic [23:0]    w_ax;
    logic           w_last;
    logic [31:0]    w_acc_n;
    logic [31:0]    w_g;
    logic [38:0]    w_t2;
    logic           w_cneg;
    logic [38:0]    w_c;
    logic [63:0]    w_sh16;
    logic [63:0]    w_sh32;
    logic [63:0]    w_sh62;
    logic [63:0]    w_term;
    logic [63:0]    w_mant_n;
    logic [31:0]    w_frac_n;
    logic [38:0]    w_l2;
    logic [38:0]    w_l2mag;
    logic [63:0]    w_dlim;
    logic [63:0]    w_s2abs;
    logic           w_zero;
    logic           w_dsat;
    logic [48:0]    w_sl;
    logic [48:0]    w_cv;
    logic [48:0]    w_enr;
    logic [48:0]    w_esl;
    logic [48:0]    w_ecv;

    gmde_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_mreq),
        .o_rsp   (w_mrsp)
    );

    gmde_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_dreq),
        .o_rsp   (w_drsp)
    );

    assign w_idx  = r_k[KW-1:0];
    assign w_w    = r_weight[w_idx];
    assign w_sraw = r_sigma[w_idx];
    assign w_s    = (w_sraw == 16'd0) ? 16'd1 : w_sraw;
    assign w_cc   = (r_ccount == 2'd0) ? 2'd1 : r_ccount;
    assign w_cnt  = (w_cc > 2'(MAX_COMPONENTS)) ? KCW'(MAX_COMPONENTS) : KCW'(w_cc);
    assign w_ax   = i_x_value[23] ? 24'(~i_x_value + 24'sd1) : i_x_value;
    assign w_last = (r_k + KCW'(1)) >= r_cnt;

    // Horner step: the reciprocal product holds floor(n / k) in bits 67:36
    assign w_acc_n = ONE31 - w_mrsp.prod[67:36];
    assign w_g     = (r_n < 7'd32) ? (w_acc_n >> r_n[4:0]) : 32'd0;
    assign w_t2    = {r_t, 1'b0};
    assign w_cneg  = w_t2 < 39'h1_0000_0000;
    assign w_c     = w_cneg ? (39'h1_0000_0000 - w_t2) : (w_t2 - 39'h1_0000_0000);

    assign w_sh16 = mulshr(w_mrsp.prod, 16);
    assign w_sh32 = mulshr(w_mrsp.prod, 32);
    assign w_sh62 = mulshr(w_mrsp.prod, 62);
    assign w_term = r_cneg ? (64'd0 - w_sh32) : w_sh32;

    assign w_mant_n = w_sh62[63] ? {1'b0, w_sh62[63:1]} : w_sh62;
    assign w_frac_n = {r_frac[30:0], w_sh62[63]};
    assign w_l2     = {7'({1'b0, r_msb}) - 7'd32, w_frac_n};
    assign w_l2mag  = w_l2[38] ? (39'd0 - w_l2) : w_l2;

    assign w_dlim  = lim61(w_drsp.quo, w_drsp.ovf);
    assign w_s2abs = r_s2[63] ? (64'd0 - r_s2) : r_s2;

    // result formatting
    assign w_zero = r_psum == 64'd0;
    assign w_dsat = r_psum[63:47] != 17'd0;
    assign w_sl   = sat48(r_xneg ? $signed(r_dsum) : $signed(64'd0 - r_dsum));
    assign w_cv   = sat48($signed(r_s2));
    assign w_enr  = sat48($signed(r_en));
    assign w_esl  = sat48(r_xneg ? $signed(64'd0 - r_r) : $signed(r_r));
    assign w_ecv  = sat48(r_s2[63] ? $signed(r_r2 + r_q) : $signed(r_r2 - r_q));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ccount <= 2'd1;
            for (int j = 0; j < MAX_COMPONENTS; j++) begin
                r_weight[j] <= (j == 0) ? 16'hFFFF : 16'h0000;
                r_sigma[j]  <= 16'd256;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_COUNT) begin
                r_ccount <= i_cfg_wdata[1:0];
            end
            for (int j = 0; j < MAX_COMPONENTS; j++) begin
                if (i_cfg_index == 3'(CFG_WEIGHT0 + 3'(j))) begin
                    r_weight[j] <= i_cfg_wdata;
                end
                if (i_cfg_index == 3'(CFG_SIGMA0 + 3'(j))) begin
                    r_sigma[j] <= i_cfg_wdata;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ovalid     <= 1'b0;
            r_mreq.start <= 1'b0;
            r_dreq.start <= 1'b0;
        end else begin
            r_mreq.start <= 1'b0;
            r_dreq.start <= 1'b0;
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_ax    <= w_ax;
                        r_xneg  <= i_x_value[23];
                        r_cnt   <= w_cnt;
                        r_k     <= '0;
                        r_psum  <= '0;
                        r_dsum  <= '0;
                        r_s2    <= '0;
                        r_mreq  <= mul_go(64'(w_ax), 64'(w_ax));
                        r_state <= S_AX2;
                    end
                end
                S_AX2: begin
                    if (w_mrsp.done) begin
                        r_ax2   <= w_mrsp.prod[46:0];
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    r_mreq  <= mul_go(64'(w_s), 64'(w_s));
                    r_state <= S_SS;
                end
                S_SS: begin
                    if (w_mrsp.done) begin
                        r_ss    <= w_mrsp.prod[31:0];
                        r_mreq  <= mul_go(64'(w_mrsp.prod[31:0]), 64'(w_s));
                        r_state <= S_SSS;
                    end
                end
                S_SSS: begin
                    if (w_mrsp.done) begin
                        r_sss   <= w_mrsp.prod[47:0];
                        r_dreq  <= div_go({r_ax2, 49'd0}, 64'(r_ss), 7'd62);
                        r_state <= S_T;
                    end
                end
                S_T: begin
                    if (w_drsp.done) begin
                        if (w_drsp.quo[63:38] != 26'd0) begin
                            if (w_last) begin
                                r_state <= S_FIN;
                            end else begin
                                r_k     <= r_k + KCW'(1);
                                r_state <= S_NEXT;
                            end
                        end else begin
                            r_t     <= w_drsp.quo[37:0];
                            r_mreq  <= mul_go(64'(w_drsp.quo[37:0]), 64'(LOG2E_Q31));
                            r_state <= S_Y;
                        end
                    end
                end
                S_Y: begin
                    if (w_mrsp.done) begin
                        r_n     <= w_mrsp.prod[69:63];
                        r_mreq  <= mul_go(64'(w_mrsp.prod[62:31]), 64'(LN2_Q31));
                        r_state <= S_Z;
                    end
                end
                S_Z: begin
                    if (w_mrsp.done) begin
                        r_z     <= w_mrsp.prod[62:32];
                        r_kk    <= 4'd12;
                        r_mreq  <= mul_go(64'(w_mrsp.prod[62:32]), 64'(ONE31));
                        r_state <= S_HM;
                    end
                end
                S_HM: begin
                    if (w_mrsp.done) begin
                        r_mreq  <= mul_go(64'(w_mrsp.prod[62:31]), 64'(horner_recip(r_kk)));
                        r_state <= S_HD;
                    end
                end
                S_HD: begin
                    if (w_mrsp.done) begin
                        if (r_kk == 4'd1) begin
                            r_mreq  <= mul_go(64'(w_w), 64'(w_g));
                            r_state <= S_WG;
                        end else begin
                            r_kk    <= r_kk - 4'd1;
                            r_mreq  <= mul_go(64'(r_z), 64'(w_acc_n));
                            r_state <= S_HM;
                        end
                    end
                end
                S_WG: begin
                    if (w_mrsp.done) begin
                        r_mreq  <= mul_go(64'(w_mrsp.prod[46:16]), 64'(INVSQRT2PI_Q32));
                        r_state <= S_M;
                    end
                end
                S_M: begin
                    if (w_mrsp.done) begin
                        r_m     <= w_mrsp.prod[61:0];
                        r_dreq  <= div_go({w_mrsp.prod[61:0], 34'd0}, 64'({w_s, 23'd0}),
                                          7'd62);
                        r_state <= S_A;
                    end
                end
                S_A: begin
                    if (w_drsp.done) begin
                        r_psum  <= r_psum + w_drsp.quo;
                        r_dreq  <= div_go({r_m, 34'd0}, 64'({r_sss, 7'd0}), 7'd62);
                        r_state <= S_B;
                    end
                end
                S_B: begin
                    if (w_drsp.done) begin
                        r_b     <= w_drsp.quo[55:0];
                        r_mreq  <= mul_go(64'(r_ax), 64'(w_drsp.quo[55:0]));
                        r_state <= S_D;
                    end
                end
                S_D: begin
                    if (w_mrsp.done) begin
                        r_dsum  <= r_dsum + w_sh16;
                        r_cneg  <= w_cneg;
                        r_mreq  <= mul_go(64'(r_b), 64'(w_c));
                        r_state <= S_C;
                    end
                end
                S_C: begin
                    if (w_mrsp.done) begin
                        r_s2 <= sat_add(r_s2, w_term);
                        if (w_last) begin
                            r_state <= S_FIN;
                        end else begin
                            r_k     <= r_k + KCW'(1);
                            r_state <= S_NEXT;
                        end
                    end
                end
                S_FIN: begin
                    if (r_dsum > LIM61) begin
                        r_dsum <= LIM61;
                    end
                    r_mant <= r_psum;
                    r_msb  <= 6'd62;
                    r_frac <= '0;
                    r_it   <= '0;
                    r_state <= w_zero ? S_OUT : S_NORM;
                end
                S_NORM: begin
                    if (r_mant[63:62] == 2'd0) begin
                        r_mant <= {r_mant[62:0], 1'b0};
                        r_msb  <= r_msb - 6'd1;
                    end else begin
                        r_mreq  <= mul_go(r_mant, r_mant);
                        r_state <= S_LSQ;
                    end
                end
                S_LSQ: begin
                    if (w_mrsp.done) begin
                        r_mant <= w_mant_n;
                        r_frac <= w_frac_n;
                        r_it   <= r_it + 5'd1;
                        if (r_it == 5'd31) begin
                            r_l2neg <= w_l2[38];
                            r_mreq  <= mul_go(64'(w_l2mag), 64'(LN2_Q32));
                            r_state <= S_LN;
                        end else begin
                            r_mreq <= mul_go(w_mant_n, w_mant_n);
                        end
                    end
                end
                S_LN: begin
                    if (w_mrsp.done) begin
                        r_en    <= r_l2neg ? w_sh32 : (64'd0 - w_sh32);
                        r_dreq  <= div_go({r_dsum, 32'd0}, r_psum, 7'd96);
                        r_state <= S_R;
                    end
                end
                S_R: begin
                    if (w_drsp.done) begin
                        r_r     <= w_dlim;
                        r_mreq  <= mul_go(w_dlim, w_dlim);
                        r_state <= S_R2;
                    end
                end
                S_R2: begin
                    if (w_mrsp.done) begin
                        r_r2    <= (w_sh32 > LIM61) ? LIM61 : w_sh32;
                        r_dreq  <= div_go({w_s2abs, 32'd0}, r_psum, 7'd96);
                        r_state <= S_Q;
                    end
                end
                S_Q: begin
                    if (w_drsp.done) begin
                        r_q     <= w_dlim;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid   <= 1'b1;
                        r_o_dens   <= w_dsat ? OUT_MAX[46:0] : r_psum[46:0];
                        r_o_dslope <= w_sl[47:0];
                        r_o_dcurv  <= w_cv[47:0];
                        if (w_zero) begin
                            r_o_en     <= OUT_MAX;
                            r_o_eslope <= OUT_MAX;
                            r_o_ecurv  <= OUT_MAX;
                            r_o_status <= ST_ZERO;
                        end else begin
                            r_o_en     <= w_enr[47:0];
                            r_o_eslope <= w_esl[47:0];
                            r_o_ecurv  <= w_ecv[47:0];
                            r_o_status <= (w_dsat || w_sl[48] || w_cv[48] || w_enr[48] ||
                                           w_esl[48] || w_ecv[48]) ? ST_SAT : ST_OK;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall             = r_state != S_IDLE;
    assign o_valid             = r_ovalid;
    assign o_density           = r_o_dens;
    assign o_density_slope     = r_o_dslope;
    assign o_density_curvature = r_o_dcurv;
    assign o_energy            = r_o_en;
    assign o_energy_slope      = r_o_eslope;
    assign o_energy_curvature  = r_o_ecurv;
    assign o_status            = r_o_status;

endmodule
`default_nettype wire

[test/gaussian_mixture_density_eval_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_mixture_density_eval_tb: self-checking bench for the mixture density evaluator
// Sends samples over the valid/stall input channel and computes each expected
// result with a fixed-point model of the density, its derivatives and the
// energy terms. Checks every output transfer in order against that model,
// using register settings that include the extreme values. Random idle gaps on
// the input and stall bursts on the output are applied, and one long output hold-off
// fills the block so that its input stalls.
// ----------------------------------------------------------------------------
module gaussian_mixture_density_eval_tb;
    import gmde_pkg::*;

    localparam logic [2:0] CFG_UNUSED = 3'd7;
    localparam int         STALL_LIMIT = 60000;
    localparam int         HOLD_CYCLES = 4000;

    typedef struct packed {
        logic [46:0] dens;
        logic [47:0] dslope;
        logic [47:0] dcurv;
        logic [47:0] en;
        logic [47:0] eslope;
        logic [47:0] ecurv;
        logic [1:0]  st;
    } t_density_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [23:0] in_x = '0;
    logic        out_stall = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    logic                o_stall, o_valid;
    logic [46:0]         o_density;
    logic signed [47:0]  o_density_slope, o_density_curvature;
    logic signed [47:0]  o_energy, o_energy_slope, o_energy_curvature;
    logic [1:0]          o_status;

    gaussian_mixture_density_eval dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (in_valid),
        .o_stall             (o_stall),
        .i_x_value           (in_x),
        .o_valid             (o_valid),
        .i_stall             (out_stall),
        .o_density           (o_density),
        .o_density_slope     (o_density_slope),
        .o_density_curvature (o_density_curvature),
        .o_energy            (o_energy),
        .o_energy_slope      (o_energy_slope),
        .o_energy_curvature  (o_energy_curvature),
        .o_status            (o_status),
        .i_cfg_we            (cfg_we),
        .i_cfg_index         (cfg_index),
        .i_cfg_wdata         (cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // register mirror
    logic [1:0]  count_m = 2'd1;
    logic [15:0] weight_m [3] = '{16'd65535, 16'd0, 16'd0};
    logic [15:0] sigma_m  [3] = '{16'd256, 16'd256, 16'd256};

    t_density_result density_q [$];
    int  mismatches = 0;
    bit  idle_en = 1'b1;
    int  hold_tok = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    int  stall_burst = 0;
    int  quiet_cycles = 0;

    // ---------------- fixed-point model ----------------
    function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
                                             input int sh);
        logic [127:0] p;
        p = (128'(a) * 128'(b)) >> sh;
        mul_shift = (p[127:64] != 64'd0) ? '1 : p[63:0];
    endfunction

    function automatic logic [63:0] ratio_q32(input logic [63:0] num, input logic [63:0] den);
        logic [95:0] q;
        if (den < (64'd1 << 33) && num >= (den << 29)) begin
            return LIM61;
        end
        q = {num, 32'd0} / {32'd0, den};
        ratio_q32 = (q > 96'(LIM61)) ? LIM61 : q[63:0];
    endfunction

    function automatic logic signed [63:0] apply_sign(input logic [63:0] mag, input logic neg);
        apply_sign = neg ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic signed [63:0] add_clamp(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) begin
            return a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        end
        add_clamp = s;
    endfunction

    function automatic logic [47:0] clamp48(input logic signed [63:0] v, inout logic sat);
        if (v > 64'sh0000_7FFF_FFFF_FFFF) begin
            sat = 1'b1;
            return OUT_MAX;
        end
        if (v < 64'shFFFF_8000_0000_0000) begin
            sat = 1'b1;
            return OUT_MIN;
        end
        clamp48 = v[47:0];
    endfunction

    // exp(-t) in Q0.31, t in Q.32 below 64
    function automatic logic [63:0] exp_q31(input logic [63:0] t);
        logic [63:0] y, n, z, acc;
        y = (t >> 32) * 64'(LOG2E_Q31) * 64'd2 + (((t & 64'hFFFF_FFFF) * 64'(LOG2E_Q31)) >> 31);
        n = y >> 32;
        z = ((y & 64'hFFFF_FFFF) * 64'(LN2_Q31)) >> 32;
        acc = 64'(ONE31);
        for (int k = 12; k >= 1; k--) begin
            acc = 64'(ONE31) - (((z * acc) >> 31) / 64'(k));
        end
        exp_q31 = (n < 64'd32) ? (acc >> n) : 64'd0;
    endfunction

    function automatic t_density_result mixture_eval(input logic [23:0] raw);
        t_density_result e;
        logic xneg, cneg, sat, s2neg, l2neg;
        logic [63:0] ax, s, t, g, m, b, c, psum, dsum, mant, r, r2, q, l2mag;
        logic signed [63:0] s2, l2;
        logic [31:0] frac;
        int cnt, msb;
        xneg = raw[23];
        ax = xneg ? (64'd1 << 24) - 64'(raw) : 64'(raw);
        cnt = (count_m == 2'd0) ? 1 : int'(count_m);
        psum = 0;
        dsum = 0;
        s2 = 0;
        sat = 1'b0;
        for (int k = 0; k < cnt; k++) begin
            s = (sigma_m[k] == 16'd0) ? 64'd1 : 64'(sigma_m[k]);
            t = ((ax * ax) << 15) / (s * s);
            if (t >= (64'd64 << 32)) continue;
            g = exp_q31(t);
            m = ((64'(weight_m[k]) * g) >> 16) * 64'(INVSQRT2PI_Q32);
            psum = psum + m / (s << 23);
            b = m / ((s * s * s) << 7);
            dsum = dsum + mul_shift(ax, b, 16);
            cneg = (t * 2) < (64'd1 << 32);
            c = cneg ? (64'd1 << 32) - t * 2 : t * 2 - (64'd1 << 32);
            s2 = add_clamp(s2, apply_sign(mul_shift(b, c, 32), cneg));
        end
        if (dsum > LIM61) dsum = LIM61;
        if (psum > 64'(OUT_MAX)) begin
            e.dens = OUT_MAX[46:0];
            sat = 1'b1;
        end else begin
            e.dens = psum[46:0];
        end
        e.dslope = clamp48(apply_sign(dsum, !xneg), sat);
        e.dcurv = clamp48(s2, sat);
        if (psum == 64'd0) begin
            e.en = OUT_MAX;
            e.eslope = OUT_MAX;
            e.ecurv = OUT_MAX;
            e.st = ST_ZERO;
            return e;
        end
        msb = 0;
        while ((psum >> (msb + 1)) != 64'd0 && msb < 62) msb++;
        mant = psum << (62 - msb);
        frac = 0;
        for (int i = 0; i < 32; i++) begin
            mant = mul_shift(mant, mant, 62);
            frac = frac << 1;
            if (mant[63]) begin
                mant = mant >> 1;
                frac[0] = 1'b1;
            end
        end
        l2 = (64'(msb) - 64'sd32) * 64'sd4294967296 + $signed(64'(frac));
        l2neg = l2 < 0;
        l2mag = l2neg ? -l2 : l2;
        e.en = clamp48(apply_sign(mul_shift(l2mag, 64'(LN2_Q32), 32), !l2neg), sat);
        r = ratio_q32(dsum, psum);
        e.eslope = clamp48(apply_sign(r, xneg), sat);
        r2 = mul_shift(r, r, 32);
        if (r2 > LIM61) r2 = LIM61;
        s2neg = s2 < 0;
        q = ratio_q32(s2neg ? -s2 : s2, psum);
        e.ecurv = clamp48($signed(r2) - apply_sign(q, s2neg), sat);
        e.st = sat ? ST_SAT : ST_OK;
        mixture_eval = e;
    endfunction

    // ---------------- output side ----------------
    always @(posedge i_clk) begin
        t_density_result e, got;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_valid && !out_stall) begin
                got = '{o_density, o_density_slope, o_density_curvature, o_energy,
                        o_energy_slope, o_energy_curvature, o_status};
                if (density_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result transfer: %p", got);
                end else begin
                    e = density_q.pop_front();
                    if (got !== e) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: expected %p", e);
                            $display("          actual   %p", got);
                        end
                    end
                end
            end
            if (hold_tok != hold_seen) begin
                hold_seen = hold_tok;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (stall_burst > 0) begin
                stall_burst--;
                out_stall <= 1'b1;
            end else if (idle_en && $urandom_range(0, 4) == 0) begin
                stall_burst = $urandom_range(1, 6) - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((in_valid && !o_stall) || (o_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > STALL_LIMIT) begin
                $display("gaussian_mixture_density_eval test failed");
                $finish;
            end
        end
    end

    // ---------------- input side ----------------
    task automatic send_x(input logic [23:0] x);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_x <= x;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        density_q.push_back(mixture_eval(x));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (density_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // leaves the write enable high; close with cfg_close
    task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        if (idx == CFG_COUNT) begin
            count_m = val[1:0];
        end else if (idx < CFG_SIGMA0) begin
            weight_m[idx - CFG_WEIGHT0] = val;
        end else if (idx < CFG_SIGMA0 + 3) begin
            sigma_m[idx - CFG_SIGMA0] = val;
        end
    endtask

    task automatic cfg_close();
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic cfg_all(input logic [1:0] cnt, input logic [15:0] w0, input logic [15:0] w1,
                           input logic [15:0] w2, input logic [15:0] s0, input logic [15:0] s1,
                           input logic [15:0] s2);
        cfg_write(CFG_COUNT, {14'd0, cnt});
        cfg_write(CFG_WEIGHT0, w0);
        cfg_write(CFG_WEIGHT0 + 3'd1, w1);
        cfg_write(CFG_WEIGHT0 + 3'd2, w2);
        cfg_write(CFG_SIGMA0, s0);
        cfg_write(CFG_SIGMA0 + 3'd1, s1);
        cfg_write(CFG_SIGMA0 + 3'd2, s2);
        cfg_close();
    endtask

    function automatic logic [23:0] near_x(input logic [15:0] sig);
        logic [31:0] span;
        span = (32'(sig == 0 ? 16'd1 : sig) << 8) * 12;
        if (span > 32'h7F_FFFF) span = 32'h7F_FFFF;
        near_x = $urandom_range(0, 1) ? 24'($urandom_range(0, span))
                                      : 24'(-$signed({1'b0, 24'($urandom_range(0, span))}));
    endfunction

    // ---------------- tests ----------------
    task automatic test_reset_values();
        send_x(24'h000000);
        send_x(24'h7FFFFF);
        send_x(24'h800000);
        send_x(24'h000001);
        send_x(24'hFFFFFF);
        send_x(24'h010000);
        send_x(24'hFF0000);
        wait_idle();
    endtask

    task automatic test_register_extremes();
        cfg_all(2'd3, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd1, 16'd0);
        send_x(24'h000000);
        send_x(24'h000100);
        send_x(24'h7FFFFF);
        wait_idle();
        cfg_all(2'd0, 16'd0, 16'd65535, 16'd0, 16'd256, 16'd256, 16'd256);
        send_x(24'h010000);
        wait_idle();
        cfg_write(CFG_UNUSED, 16'hFFFF);
        cfg_write(CFG_WEIGHT0, 16'd40000);
        cfg_close();
        send_x(24'hFE8000);
        wait_idle();
    endtask

    task automatic test_saturation();
        cfg_all(2'd3, 16'd65535, 16'd65535, 16'd65535, 16'd1, 16'd1, 16'd2);
        send_x(24'h000000);
        send_x(24'h000040);
        send_x(24'hFFFFC0);
        send_x(24'h000200);
        wait_idle();
    endtask

    task automatic test_zero_density();
        cfg_all(2'd2, 16'd65535, 16'd65535, 16'd0, 16'd1, 16'd1, 16'd256);
        send_x(24'h7FFFFF);
        send_x(24'h800000);
        wait_idle();
        cfg_all(2'd3, 16'd0, 16'd0, 16'd0, 16'd256, 16'd512, 16'd1024);
        send_x(24'h000000);
        wait_idle();
    endtask

    task automatic test_output_holdoff();
        cfg_all(2'd1, 16'd50000, 16'd0, 16'd0, 16'd300, 16'd256, 16'd256);
        hold_tok++;
        repeat (4) send_x(near_x(16'd300));
        wait_idle();
    endtask

    task automatic test_random_mixtures();
        logic [15:0] sg [3];
        logic [1:0]  cnt;
        for (int ph = 0; ph < 20; ph++) begin
            if (ph >= 16) idle_en = 1'b0;
            cnt = 2'($urandom_range(0, 3));
            for (int k = 0; k < 3; k++) begin
                case ($urandom_range(0, 5))
                    0: sg[k] = 16'($urandom_range(0, 65535));
                    1: sg[k] = 16'($urandom_range(0, 16));
                    default: sg[k] = 16'($urandom_range(32, 4096));
                endcase
            end
            cfg_all(cnt, 16'($urandom), 16'($urandom), 16'($urandom), sg[0], sg[1], sg[2]);
            for (int n = 0; n < 51; n++) begin
                if ($urandom_range(0, 2) == 0) begin
                    send_x(24'($urandom));
                end else begin
                    send_x(near_x(sg[$urandom_range(0, 2)]));
                end
            end
            wait_idle();
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_register_extremes();
        test_saturation();
        test_zero_density();
        test_output_holdoff();
        test_random_mixtures();
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && density_q.size() == 0) begin
            $display("gaussian_mixture_density_eval test passed");
        end else begin
            $display("gaussian_mixture_density_eval test failed");
        end
        $finish;
    end

endmodule
